// ----- sv/ltkm_pkg.sv -----
// Package of shared constants and item types for the loser-tree merge core.
`default_nettype none

package ltkm_pkg;

  // Number of runs (tree leaves); field widths below are sized for this value.
  localparam int RUNS    = 8;
  localparam int LEAF_W  = $clog2(RUNS);
  localparam int SLOT_W  = $clog2(RUNS + 1);
  localparam int NODE_W  = $clog2(RUNS);
  localparam int VALUE_W = 32;
  localparam int COUNT_W = 32;

  // Slot code for the empty marker that beats every leaf.
  localparam logic [SLOT_W-1:0] EMPTY_MARK = SLOT_W'(RUNS);

  // Value stored into a leaf that is loaded as empty.
  localparam logic signed [VALUE_W-1:0] TOP_VALUE = {1'b0, {(VALUE_W-1){1'b1}}};

  typedef enum logic {
    OP_LOAD    = 1'b0,
    OP_ADVANCE = 1'b1
  } op_t;

  typedef struct packed {
    logic                      op;
    logic [2:0]                run_index;
    logic signed [VALUE_W-1:0] new_value;
    logic                      new_valid;
  } in_item_t;

  typedef struct packed {
    logic signed [VALUE_W-1:0] out_value;
    logic [2:0]                out_run;
    logic                      out_valid;
    logic [3:0]                winner_run;
    logic                      winner_valid;
    logic [COUNT_W-1:0]        pops_done;
  } out_item_t;

endpackage

`default_nettype wire

// ----- sv/loser_tree_kway_merge_core.sv -----
// Tournament loser-tree K-way merge engine with a one-level-per-cycle replay unit.
//
// Usage: each input item is either a load (write one run head into its leaf) or an
// advance (emit the current winner, refill its leaf from the item). Both replay the
// touched leaf's path to the root through a single shared compare unit that plays
// one tree level per cycle. After reset, the user loads heads from the last run down
// to run 0; the core does not enforce it. Every item produces exactly one result item
// carrying the emitted winner, the new root winner and the saturating advance count.
// Channels: in_valid/in_stall/in_data and out_valid/out_stall/out_data; an item
// moves at a rising edge with valid high and stall low.
// Sequence: the accepting edge writes the leaf, ST_PLAY replays the path up to the
// root and ST_DONE moves the result into the output register. An advance that finds
// the empty marker at the root skips the replay and goes straight to ST_DONE.
// in_stall is high from acceptance until the result has been moved into the output
// register, so no new item is taken while one is still in flight.
// Reset (synchronous, rst_n low) empties the tree: every slot holds the empty
// marker, every leaf is inactive and the advance count is zero.
// When the receiver stalls, the result waits in the output register; the engine
// may finish the next item's replay meanwhile, but holds it until the register frees.
`default_nettype none

module loser_tree_kway_merge_core
  import ltkm_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_stall,
  input  wire in_item_t  in_data,
  output logic           out_valid,
  input  wire logic      out_stall,
  output out_item_t      out_data
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_PLAY = 3'b010,
    ST_DONE = 3'b100
  } state_t;

  state_t state_r, state_nxt;

  // Tree state: leaf heads, their active flags and the loser held at each node.
  // Slot 0 holds the overall winner.
  logic signed [VALUE_W-1:0] leaf_value_r  [RUNS];
  logic signed [VALUE_W-1:0] leaf_value_nxt[RUNS];
  logic [RUNS-1:0]           leaf_active_r, leaf_active_nxt;
  logic [SLOT_W-1:0]         loser_slot_r  [RUNS];
  logic [SLOT_W-1:0]         loser_slot_nxt[RUNS];
  logic [COUNT_W-1:0]        pop_count_r, pop_count_nxt;

  // Climber carried up the path, with its value and flag held locally so the
  // compare unit only needs one read of the leaf store per level.
  logic [SLOT_W-1:0]         clb_r, clb_nxt;
  logic                      clb_act_r, clb_act_nxt;
  logic signed [VALUE_W-1:0] clb_val_r, clb_val_nxt;
  logic [NODE_W-1:0]         node_r, node_nxt;

  // Current root and whether it is an active leaf.
  logic [SLOT_W-1:0]         win_run_r, win_run_nxt;
  logic                      win_act_r, win_act_nxt;

  // Emitted winner captured at an advance.
  logic signed [VALUE_W-1:0] em_value_r, em_value_nxt;
  logic [2:0]                em_run_r, em_run_nxt;
  logic                      em_valid_r, em_valid_nxt;

  logic                      out_valid_r, out_valid_nxt;
  out_item_t                 out_data_r, out_data_nxt;

  // Shared read port and compare unit.
  logic [SLOT_W-1:0]         stored_slot;
  logic [LEAF_W-1:0]         rd_idx;
  logic signed [VALUE_W-1:0] rd_val;
  logic                      rd_act;
  logic                      clb_leaf;
  logic                      stored_leaf;
  logic                      stored_beats;
  logic                      out_free;

  // Replay start helpers.
  logic                      start_replay;
  logic [LEAF_W-1:0]         start_leaf;
  logic [SLOT_W:0]           start_node_sum;

  assign stored_slot = loser_slot_r[node_r];
  assign rd_idx      = (state_r == ST_IDLE) ? loser_slot_r[0][LEAF_W-1:0]
                                            : stored_slot[LEAF_W-1:0];
  assign rd_val      = leaf_value_r[rd_idx];
  assign rd_act      = leaf_active_r[rd_idx];

  // Match rule: an inactive climber always loses; the empty marker beats any leaf;
  // between two active leaves the stored one wins only when strictly smaller.
  assign clb_leaf    = (clb_r < EMPTY_MARK);
  assign stored_leaf = (stored_slot < EMPTY_MARK);
  always_comb begin
    if (clb_leaf && !clb_act_r) begin
      stored_beats = 1'b1;
    end else if (!stored_leaf) begin
      stored_beats = clb_leaf;
    end else if (!clb_leaf) begin
      stored_beats = 1'b0;
    end else begin
      stored_beats = rd_act && (rd_val < clb_val_r);
    end
  end

  assign out_free       = !out_valid_r || !out_stall;
  assign start_node_sum = ({1'b0, SLOT_W'(start_leaf)} + (SLOT_W + 1)'(RUNS)) >> 1;

  always_comb begin
    state_nxt       = state_r;
    leaf_value_nxt  = leaf_value_r;
    leaf_active_nxt = leaf_active_r;
    loser_slot_nxt  = loser_slot_r;
    pop_count_nxt   = pop_count_r;
    clb_nxt         = clb_r;
    clb_act_nxt     = clb_act_r;
    clb_val_nxt     = clb_val_r;
    node_nxt        = node_r;
    win_run_nxt     = win_run_r;
    win_act_nxt     = win_act_r;
    em_value_nxt    = em_value_r;
    em_run_nxt      = em_run_r;
    em_valid_nxt    = em_valid_r;
    out_valid_nxt   = out_valid_r;
    out_data_nxt    = out_data_r;
    start_replay    = 1'b0;
    start_leaf      = in_data.run_index[LEAF_W-1:0];

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          em_value_nxt = '0;
          em_run_nxt   = '0;
          em_valid_nxt = 1'b0;
          if (in_data.op == OP_LOAD) begin
            if ({1'b0, in_data.run_index} < (SLOT_W + 1)'(RUNS)) begin
              start_replay = 1'b1;
            end
          end else begin
            if (pop_count_r != '1) begin
              pop_count_nxt = pop_count_r + 1'b1;
            end
            if (loser_slot_r[0] < EMPTY_MARK) begin
              start_leaf   = loser_slot_r[0][LEAF_W-1:0];
              start_replay = 1'b1;
              if (rd_act) begin
                em_value_nxt = rd_val;
                em_run_nxt   = 3'(loser_slot_r[0]);
                em_valid_nxt = 1'b1;
              end
            end
          end
          if (start_replay) begin
            leaf_active_nxt[start_leaf] = in_data.new_valid;
            leaf_value_nxt[start_leaf]  = in_data.new_valid ? in_data.new_value : TOP_VALUE;
            clb_nxt     = SLOT_W'(start_leaf);
            clb_act_nxt = in_data.new_valid;
            clb_val_nxt = in_data.new_valid ? in_data.new_value : TOP_VALUE;
            node_nxt    = start_node_sum[NODE_W-1:0];
            state_nxt   = ST_PLAY;
          end else begin
            state_nxt = ST_DONE;
          end
        end
      end

      ST_PLAY: begin
        if (stored_beats) begin
          loser_slot_nxt[node_r] = clb_r;
          clb_nxt     = stored_slot;
          clb_act_nxt = stored_leaf && rd_act;
          clb_val_nxt = rd_val;
        end
        node_nxt = node_r >> 1;
        if ((node_r >> 1) == '0) begin
          loser_slot_nxt[0] = stored_beats ? stored_slot : clb_r;
          win_run_nxt       = stored_beats ? stored_slot : clb_r;
          win_act_nxt       = stored_beats ? (stored_leaf && rd_act) : clb_act_r;
          state_nxt         = ST_DONE;
        end
      end

      ST_DONE: begin
        if (out_free) begin
          out_data_nxt.out_value    = em_value_r;
          out_data_nxt.out_run      = em_run_r;
          out_data_nxt.out_valid    = em_valid_r;
          out_data_nxt.winner_run   = 4'(win_run_r);
          out_data_nxt.winner_valid = win_act_r;
          out_data_nxt.pops_done    = pop_count_r;
          out_valid_nxt             = 1'b1;
          state_nxt                 = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      leaf_active_r <= '0;
      for (int i = 0; i < RUNS; i++) begin
        loser_slot_r[i] <= EMPTY_MARK;
      end
      pop_count_r   <= '0;
      win_run_r     <= EMPTY_MARK;
      win_act_r     <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      leaf_active_r <= leaf_active_nxt;
      loser_slot_r  <= loser_slot_nxt;
      pop_count_r   <= pop_count_nxt;
      win_run_r     <= win_run_nxt;
      win_act_r     <= win_act_nxt;
      out_valid_r   <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    leaf_value_r <= leaf_value_nxt;
    clb_r        <= clb_nxt;
    clb_act_r    <= clb_act_nxt;
    clb_val_r    <= clb_val_nxt;
    node_r       <= node_nxt;
    em_value_r   <= em_value_nxt;
    em_run_r     <= em_run_nxt;
    em_valid_r   <= em_valid_nxt;
    out_data_r   <= out_data_nxt;
  end

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire

// ----- bench/tb_loser_tree_kway_merge_core.sv -----
// Self-checking testbench for the loser-tree K-way merge core.
`default_nettype none

module tb_loser_tree_kway_merge_core;
  import ltkm_pkg::*;

  // Generous ceiling on the run length, in clock cycles.
  localparam int CYCLE_LIMIT = 400000;
  // Roughly how many items the random merge sessions send before the noise phase.
  localparam int MERGE_ITEMS = 1400;
  localparam int NOISE_ITEMS = 300;
  // Quiet period after the last result.
  localparam int SETTLE_CYCLES = 20;

  logic      clk;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_stall;
  in_item_t  in_data   = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_data;

  loser_tree_kway_merge_core DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Shadow copy of the tournament tree: leaf heads, their active flags, the loser
  // held at each internal node (node 0 holds the overall winner) and the pop count.
  logic signed [VALUE_W-1:0] leaf_val [RUNS];
  logic                      leaf_on  [RUNS];
  logic [SLOT_W-1:0]         slot     [RUNS];
  logic [COUNT_W-1:0]        pop_total;

  // Results the tree should produce, oldest first.
  out_item_t pending_results [$];
  out_item_t due;

  int  faults      = 0;
  int  cycles      = 0;
  int  items_sent  = 0;
  int  loads_sent  = 0;
  int  advances    = 0;
  int  emitted     = 0;
  int  root_empty  = 0;
  int  root_dead   = 0;
  int  results_got = 0;
  bit  no_idle     = 1'b0;

  // The node's stored entry wins the match (and the two trade places) when the
  // climber is a dead leaf, when the stored entry is the empty marker and the
  // climber a leaf, or when both are live leaves and the stored value is strictly
  // smaller. On equal values the incumbent stays put.
  function automatic bit resident_wins(logic [SLOT_W-1:0] held, logic [SLOT_W-1:0] climber);
    if (climber < RUNS && !leaf_on[climber[LEAF_W-1:0]]) return 1'b1;
    if (held >= RUNS) return climber < RUNS;
    if (climber >= RUNS) return 1'b0;
    return leaf_on[held[LEAF_W-1:0]] &&
           (leaf_val[held[LEAF_W-1:0]] < leaf_val[climber[LEAF_W-1:0]]);
  endfunction

  function automatic void replay_path(int leaf);
    logic [SLOT_W-1:0] climber;
    logic [SLOT_W-1:0] swap;
    int                node;
    climber = SLOT_W'(leaf);
    node    = (leaf + RUNS) / 2;
    while (node > 0) begin
      if (resident_wins(slot[node], climber)) begin
        swap       = slot[node];
        slot[node] = climber;
        climber    = swap;
      end
      node = node / 2;
    end
    slot[0] = climber;
  endfunction

  function automatic void write_head(int leaf, logic signed [VALUE_W-1:0] v, logic live);
    leaf_on[leaf]  = live;
    leaf_val[leaf] = live ? v : TOP_VALUE;
  endfunction

  function automatic void clear_tree();
    for (int i = 0; i < RUNS; i++) begin
      leaf_val[i] = '0;
      leaf_on[i]  = 1'b0;
      slot[i]     = EMPTY_MARK;
    end
    pop_total = '0;
  endfunction

  // Applies one accepted item to the shadow tree and returns the result it causes.
  function automatic out_item_t tree_step(in_item_t it);
    out_item_t         r;
    logic [SLOT_W-1:0] win;
    r = '0;
    if (it.op == OP_LOAD) begin
      write_head(int'(it.run_index), it.new_value, it.new_valid);
      replay_path(int'(it.run_index));
    end else begin
      win = slot[0];
      if (win < RUNS) begin
        if (leaf_on[win[LEAF_W-1:0]]) begin
          r.out_value = leaf_val[win[LEAF_W-1:0]];
          r.out_run   = win[LEAF_W-1:0];
          r.out_valid = 1'b1;
        end
        write_head(int'(win), it.new_value, it.new_valid);
        replay_path(int'(win));
      end
      if (pop_total != '1) pop_total = pop_total + 1'b1;
    end
    r.winner_run   = slot[0];
    r.winner_valid = (slot[0] < RUNS) ? leaf_on[slot[0][LEAF_W-1:0]] : 1'b0;
    r.pops_done    = pop_total;
    return r;
  endfunction

  // Offers one item, with random idle cycles ahead of it, and waits until it is
  // taken. in_valid drops at the falling edge that follows, so an item that has
  // been taken is never offered again while the core is busy.
  task automatic send_item(in_item_t it);
    out_item_t r;
    @(negedge clk);
    while (!no_idle && $urandom_range(99) < 33) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (in_stall);
    if (it.op == OP_LOAD) loads_sent++;
    else begin
      advances++;
      if (slot[0] >= RUNS) root_empty++;
      else if (!leaf_on[slot[0][LEAF_W-1:0]]) root_dead++;
    end
    r = tree_step(it);
    if (r.out_valid) emitted++;
    pending_results.push_back(r);
    items_sent++;
    @(negedge clk);
    in_valid <= 1'b0;
  endtask

  task automatic load_head(int run, logic signed [VALUE_W-1:0] v, logic live);
    in_item_t it;
    it.op        = OP_LOAD;
    it.run_index = 3'(run);
    it.new_value = v;
    it.new_valid = live;
    send_item(it);
  endtask

  task automatic advance(logic signed [VALUE_W-1:0] v, logic live);
    in_item_t it;
    it.op        = OP_ADVANCE;
    it.run_index = 3'($urandom_range(7));
    it.new_value = v;
    it.new_valid = live;
    send_item(it);
  endtask

  // Head values: a narrow band that makes ties common, the full range, or values
  // hugging the two ends of the signed range.
  function automatic logic signed [VALUE_W-1:0] head_value(int span);
    case (span)
      0: return VALUE_W'(int'($urandom_range(12)) - 6);
      1: return VALUE_W'($urandom);
      default: begin
        if ($urandom_range(1)) return 32'h7FFF_FFFF - $urandom_range(3);
        return 32'h8000_0000 + $urandom_range(3);
      end
    endcase
  endfunction

  // Next value of a sorted run: never below the current head, clamped at the top.
  function automatic logic signed [VALUE_W-1:0] follow_on(logic signed [VALUE_W-1:0] cur,
                                                          int spread);
    longint nxt;
    nxt = longint'(cur) + longint'($urandom_range(spread));
    if (nxt > 64'sd2147483647) nxt = 64'sd2147483647;
    return nxt[VALUE_W-1:0];
  endfunction

  // Receiver back-pressure.
  always @(negedge clk) begin
    out_stall <= no_idle ? 1'b0 : ($urandom_range(99) < 33);
  end

  // Result checker: every item taken from the tree must match the oldest prediction.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      results_got++;
      if (pending_results.size() == 0) begin
        $error("unexpected result item: winner_run %0d pops_done %0d",
               out_data.winner_run, out_data.pops_done);
        faults++;
      end else begin
        due = pending_results.pop_front();
        if (out_data.out_value !== due.out_value) begin
          $error("out_value: expected %0d, got %0d", due.out_value, out_data.out_value);
          faults++;
        end
        if (out_data.out_run !== due.out_run) begin
          $error("out_run: expected %0d, got %0d", due.out_run, out_data.out_run);
          faults++;
        end
        if (out_data.out_valid !== due.out_valid) begin
          $error("out_valid: expected %0b, got %0b", due.out_valid, out_data.out_valid);
          faults++;
        end
        if (out_data.winner_run !== due.winner_run) begin
          $error("winner_run: expected %0d, got %0d", due.winner_run, out_data.winner_run);
          faults++;
        end
        if (out_data.winner_valid !== due.winner_valid) begin
          $error("winner_valid: expected %0b, got %0b", due.winner_valid,
                 out_data.winner_valid);
          faults++;
        end
        if (out_data.pops_done !== due.pops_done) begin
          $error("pops_done: expected %0d, got %0d", due.pops_done, out_data.pops_done);
          faults++;
        end
      end
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Timed out after %0d cycles with %0d results outstanding.",
               cycles, pending_results.size());
      $display("tb_loser_tree_kway_merge_core NOT OK");
      $finish;
    end
  end

  // Straight after reset the root holds the empty marker, so an advance emits
  // nothing, writes no leaf and only bumps the pop count.
  task automatic test_empty_root();
    advance(32'sd99, 1'b1);
  endtask

  // Builds the tree from the last run down to run 0 with the extremes of the value
  // range, equal heads and one empty run, then drains it. Refills include ends of
  // run, so the root eventually holds a dead leaf; the final refill revives it.
  task automatic test_build_and_drain();
    load_head(7, 32'sh7FFF_FFFF, 1'b1);
    load_head(6, 32'sh8000_0000, 1'b1);
    load_head(5, 32'sd0, 1'b1);
    load_head(4, -32'sd1, 1'b1);
    load_head(3, 32'sd0, 1'b1);
    load_head(2, 32'sd17, 1'b0);
    load_head(1, 32'sd5, 1'b1);
    load_head(0, 32'sd0, 1'b1);
    advance(-32'sd1, 1'b1);
    advance(32'sd0, 1'b0);
    advance(32'sh7FFF_FFFF, 1'b1);
    advance(32'sd0, 1'b0);
    advance(32'sd5, 1'b1);
    advance(32'sd0, 1'b0);
    advance(32'sd0, 1'b0);
    advance(32'sd0, 1'b0);
    advance(32'sd0, 1'b0);
    advance(32'sd0, 1'b0);
    advance(32'sd0, 1'b0);
    advance(32'sd0, 1'b0);
    advance(32'sd42, 1'b1);
  endtask

  // One merge session: (re)load the heads from the last run down, now and then
  // stopping short so that the empty marker may remain, then advance through the
  // sorted runs until the winner goes dead or the session length runs out.
  task automatic merge_session(int span);
    int                        r;
    int                        lowest;
    int                        steps;
    int                        spread;
    logic [SLOT_W-1:0]         top;
    logic signed [VALUE_W-1:0] head;
    lowest = ($urandom_range(4) == 0) ? $urandom_range(RUNS - 1) : 0;
    spread = (span == 0) ? 2 : ((span == 1) ? (1 << 20) : 1);
    for (r = RUNS - 1; r >= lowest; r--) load_head(r, head_value(span), $urandom_range(11) != 0);
    steps = $urandom_range(60, 8);
    repeat (steps) begin
      top = slot[0];
      if (top >= RUNS || !leaf_on[top[LEAF_W-1:0]]) break;
      head = leaf_val[top[LEAF_W-1:0]];
      if ($urandom_range(7) == 0) advance(head_value(span), $urandom_range(9) != 0);
      else advance(follow_on(head, spread), $urandom_range(9) != 0);
    end
    if ($urandom_range(3) == 0) advance(VALUE_W'($urandom), $urandom_range(1));
  endtask

  task automatic test_random_merges();
    int session;
    session = 0;
    while (items_sent < MERGE_ITEMS) begin
      // A stretch in the middle runs with neither side idling.
      no_idle = (items_sent >= 600 && items_sent < 800);
      merge_session($urandom_range(2));
      session++;
    end
    no_idle = 1'b0;
    $display("Random merges: %0d sessions.", session);
  endtask

  // Unstructured items: loads to any run in any order, repeated loads and advances
  // with arbitrary refills.
  task automatic test_noise();
    in_item_t it;
    repeat (NOISE_ITEMS) begin
      it.op        = $urandom_range(1) ? OP_ADVANCE : OP_LOAD;
      it.run_index = 3'($urandom_range(7));
      it.new_value = head_value($urandom_range(2));
      it.new_valid = ($urandom_range(3) != 0);
      send_item(it);
    end
  endtask

  initial begin
    clear_tree();
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_empty_root();
    test_build_and_drain();
    test_random_merges();
    test_noise();

    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Sent %0d items (%0d loads, %0d advances); %0d results checked.",
             items_sent, loads_sent, advances, results_got);
    $display("Winners emitted %0d; advances on an empty root %0d, on a dead leaf %0d.",
             emitted, root_empty, root_dead);
    if (faults == 0) begin
      $display("tb_loser_tree_kway_merge_core OK");
    end else begin
      $display("tb_loser_tree_kway_merge_core NOT OK");
    end
    $finish;
  end

endmodule

`default_nettype wire
